[hw/rtl/magnetometer_hard_iron_calibration_core_macros.svh]
// Assertion helpers for the hard-iron calibration core.
`ifndef MAGNETOMETER_HARD_IRON_CALIBRATION_CORE_MACROS_SVH
`define MAGNETOMETER_HARD_IRON_CALIBRATION_CORE_MACROS_SVH

`ifndef SYNTH
`define MHIC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MHIC_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MHIC_ASSERT(lbl, prop, msg)
`define MHIC_ASSERT_NR(lbl, prop, msg)
`endif

`endif

[hw/rtl/mhic_pkg.sv]
package mhic_pkg;

  localparam int SMP_W = 16;
  localparam int THR_W = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic signed [SMP_W-1:0] MAX_RESET = -16'sd10000;
  localparam logic signed [SMP_W-1:0] MIN_RESET = 16'sd10000;
  localparam logic [THR_W-1:0] THRESH_RESET = 16'd100;

  typedef enum logic {
    REG_SPAN_THRESHOLD = 1'b0,
    REG_UNUSED         = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic restart;
    logic track;
    logic commit;
  } ctl_t;

endpackage

[hw/rtl/magnetometer_hard_iron_calibration_core.sv]
// Hard-iron calibration by min/max midpoint. One transaction per clock sustained
// unless out_stall holds; path: input register, then result register. Per transaction:
// restart loads each axis min/max with the sample, track widens them, commit sets
// the axis offset to (max+min)/2 (toward zero) where |max-min| > span_threshold.
// The result is sample minus the updated offset, saturated, plus per-axis accepted
// flags. span_threshold lives at byte address 0 (reset 100); write only when idle.
`include "magnetometer_hard_iron_calibration_core_macros.svh"

module magnetometer_hard_iron_calibration_core import mhic_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [SMP_W-1:0] in_sample_x,
  input  logic signed [SMP_W-1:0] in_sample_y,
  input  logic signed [SMP_W-1:0] in_sample_z,
  input  logic                    in_restart,
  input  logic                    in_track,
  input  logic                    in_commit,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [SMP_W-1:0] out_corrected_x,
  output logic signed [SMP_W-1:0] out_corrected_y,
  output logic signed [SMP_W-1:0] out_corrected_z,
  output logic                    out_accepted_x,
  output logic                    out_accepted_y,
  output logic                    out_accepted_z,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CFG_ADDR_W-1:0]   paddr,
  input  logic [CFG_DATA_W-1:0]   pwdata,
  output logic [CFG_DATA_W-1:0]   prdata,
  output logic                    pready
);

  logic                    in_valid_r;
  logic signed [SMP_W-1:0] sx_r, sy_r, sz_r;
  ctl_t                    ctl_r;
  logic                    out_valid_r;
  logic signed [SMP_W-1:0] cx_r, cy_r, cz_r;
  logic                    ax_r, ay_r, az_r;
  logic signed [SMP_W-1:0] cx, cy, cz;
  logic                    ax, ay, az;
  logic [THR_W-1:0]        threshold;
  logic                    adv, in_acc;

  assign adv = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !adv;
  assign in_acc = in_valid && !in_stall;

  mhic_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .threshold
  );

  mhic_axis u_axis_x (
    .clk, .rst_n, .upd(adv), .ctl(ctl_r), .sample(sx_r), .threshold,
    .corrected(cx), .accepted(ax)
  );

  mhic_axis u_axis_y (
    .clk, .rst_n, .upd(adv), .ctl(ctl_r), .sample(sy_r), .threshold,
    .corrected(cy), .accepted(ay)
  );

  mhic_axis u_axis_z (
    .clk, .rst_n, .upd(adv), .ctl(ctl_r), .sample(sz_r), .threshold,
    .corrected(cz), .accepted(az)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_acc) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sx_r  <= in_sample_x;
      sy_r  <= in_sample_y;
      sz_r  <= in_sample_z;
      ctl_r <= '{restart: in_restart, track: in_track, commit: in_commit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx_r <= cx;
      cy_r <= cy;
      cz_r <= cz;
      ax_r <= ax;
      ay_r <= ay;
      az_r <= az;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_corrected_x = cx_r;
  assign out_corrected_y = cy_r;
  assign out_corrected_z = cz_r;
  assign out_accepted_x  = ax_r;
  assign out_accepted_y  = ay_r;
  assign out_accepted_z  = az_r;

  `MHIC_ASSERT(a_stall_needs_item, in_stall |-> in_valid_r, "stall with empty input register")
  `MHIC_ASSERT(a_item_moves, (in_valid_r && !out_stall) |=> out_valid_r,
    "pending transaction did not reach result register")
  `MHIC_ASSERT(a_no_stall_when_empty, !out_valid_r |-> !in_stall,
    "input stalled while result register empty")

endmodule

[hw/rtl/mhic_axis.sv]
`include "magnetometer_hard_iron_calibration_core_macros.svh"

module mhic_axis import mhic_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    upd,
  input  ctl_t                    ctl,
  input  logic signed [SMP_W-1:0] sample,
  input  logic [THR_W-1:0]        threshold,
  output logic signed [SMP_W-1:0] corrected,
  output logic                    accepted
);

  logic signed [SMP_W-1:0] min_r, max_r, off_r;
  logic signed [SMP_W-1:0] min_nxt, max_nxt, off_nxt;
  logic signed [SMP_W-1:0] lo_a, hi_a, mid;
  logic signed [SMP_W:0]   span, sum, sum_adj, diff;
  logic [SMP_W:0]          span_mag;

  always_comb begin
    lo_a = ctl.restart ? sample : min_r;
    hi_a = ctl.restart ? sample : max_r;
    min_nxt = (ctl.track && (sample < lo_a)) ? sample : lo_a;
    max_nxt = (ctl.track && (sample > hi_a)) ? sample : hi_a;

    span = {max_nxt[SMP_W-1], max_nxt} - {min_nxt[SMP_W-1], min_nxt};
    span_mag = span[SMP_W] ? 17'(-span) : 17'(span);
    accepted = ctl.commit && (span_mag > {1'b0, threshold});

    // truncate toward zero
    sum = {max_nxt[SMP_W-1], max_nxt} + {min_nxt[SMP_W-1], min_nxt};
    sum_adj = sum + {{SMP_W{1'b0}}, sum[SMP_W]};
    mid = sum_adj[SMP_W:1];
    off_nxt = accepted ? mid : off_r;

    diff = {sample[SMP_W-1], sample} - {off_nxt[SMP_W-1], off_nxt};
    if (diff[SMP_W] != diff[SMP_W-1]) begin
      corrected = diff[SMP_W] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}};
    end else begin
      corrected = diff[SMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= MIN_RESET;
      max_r <= MAX_RESET;
      off_r <= '0;
    end else if (upd) begin
      min_r <= min_nxt;
      max_r <= max_nxt;
      off_r <= off_nxt;
    end
  end

  `MHIC_ASSERT(a_restart_collapses, (upd && ctl.restart) |=> (min_r == max_r),
    "restart did not collapse min/max")
  `MHIC_ASSERT(a_track_bounds, (upd && ctl.track) |=>
    ((min_r <= $past(sample)) && (max_r >= $past(sample))), "tracked sample outside bounds")
  `MHIC_ASSERT(a_offset_hold, (upd && !ctl.commit) |=> $stable(off_r),
    "offset changed without commit")

endmodule

[hw/rtl/mhic_cfg.sv]
module mhic_cfg import mhic_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [THR_W-1:0]      threshold
);

  logic [THR_W-1:0] thr_r;
  reg_idx_t         idx;
  logic             wr;

  assign idx = reg_idx_t'(paddr[CFG_ADDR_W-1]);
  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign threshold = thr_r;

  always_comb begin
    unique case (idx)
      REG_SPAN_THRESHOLD: prdata = {{(CFG_DATA_W-THR_W){1'b0}}, thr_r};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESH_RESET;
    end else if (wr && (idx == REG_SPAN_THRESHOLD)) begin
      thr_r <= pwdata[THR_W-1:0];
    end
  end

endmodule

[bench/hard_iron_checker.sv]
module hard_iron_checker import mhic_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [SMP_W-1:0]      in_sample_x,
  input  logic [SMP_W-1:0]      in_sample_y,
  input  logic [SMP_W-1:0]      in_sample_z,
  input  logic                  in_restart,
  input  logic                  in_track,
  input  logic                  in_commit,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [SMP_W-1:0]      out_corrected_x,
  input  logic [SMP_W-1:0]      out_corrected_y,
  input  logic [SMP_W-1:0]      out_corrected_z,
  input  logic                  out_accepted_x,
  input  logic                  out_accepted_y,
  input  logic                  out_accepted_z,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_ADDR_W-1:0] SPAN_THRESHOLD_ADDR =
    CFG_ADDR_W'(4 * int'(REG_SPAN_THRESHOLD));

  typedef struct packed {
    logic [2:0][SMP_W-1:0] corr;
    logic [2:0]            acc;
  } correction_t;

  logic [THR_W-1:0] span_limit;
  int               axis_max [3];
  int               axis_min [3];
  int               axis_off [3];
  correction_t      expected_corrections [$];

  function automatic correction_t predict_correction(input logic [2:0][SMP_W-1:0] smp,
                                                     input ctl_t ctl);
    correction_t r;
    int s;
    int span;
    int diff;
    r = '0;
    for (int a = 0; a < 3; a++) begin
      s = int'($signed(smp[a]));
      if (ctl.restart) begin
        axis_max[a] = s;
        axis_min[a] = s;
      end
      if (ctl.track) begin
        if (s > axis_max[a]) axis_max[a] = s;
        if (s < axis_min[a]) axis_min[a] = s;
      end
      if (ctl.commit) begin
        span = axis_max[a] - axis_min[a];
        if (span < 0) span = -span;
        if (span > int'(span_limit)) begin
          axis_off[a] = (axis_max[a] + axis_min[a]) / 2;
          r.acc[a] = 1'b1;
        end
      end
      diff = s - axis_off[a];
      if (diff > 32767) diff = 32767;
      else if (diff < -32768) diff = -32768;
      r.corr[a] = SMP_W'(diff);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    correction_t want;
    correction_t got;
    byte         tag;
    if (!rst_n) begin
      span_limit = THRESH_RESET;
      for (int a = 0; a < 3; a++) begin
        axis_max[a] = int'(MAX_RESET);
        axis_min[a] = int'(MIN_RESET);
        axis_off[a] = 0;
      end
      expected_corrections.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == SPAN_THRESHOLD_ADDR)
        span_limit = pwdata[THR_W-1:0];
      if (in_valid && !in_stall)
        expected_corrections.push_back(predict_correction(
          {in_sample_z, in_sample_y, in_sample_x},
          ctl_t'({in_restart, in_track, in_commit})));
      if (out_valid && !out_stall) begin
        got.corr = {out_corrected_z, out_corrected_y, out_corrected_x};
        got.acc  = {out_accepted_z, out_accepted_y, out_accepted_x};
        if (expected_corrections.size() == 0) begin
          $display("%0t: unexpected transaction corrected=%h accepted=%b",
                   $time, got.corr, got.acc);
          fail_count++;
        end else begin
          want = expected_corrections.pop_front();
          for (int a = 0; a < 3; a++) begin
            tag = byte'("x" + a);
            if (got.corr[a] !== want.corr[a]) begin
              $display("%0t: corrected_%c expected %0d got %0d", $time, tag,
                       $signed(want.corr[a]), $signed(got.corr[a]));
              fail_count++;
            end
            if (got.acc[a] !== want.acc[a]) begin
              $display("%0t: accepted_%c expected %b got %b", $time, tag,
                       want.acc[a], got.acc[a]);
              fail_count++;
            end
          end
        end
      end
    end
    pending = expected_corrections.size();
  end

endmodule

[bench/tb_magnetometer_hard_iron_calibration_core.sv]
module tb_magnetometer_hard_iron_calibration_core;
  import mhic_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_ITEMS = 100;
  localparam int PHASES = 8;
  localparam int STALL_LIMIT = 2000;
  localparam logic [CFG_ADDR_W-1:0] SPAN_THRESHOLD_ADDR =
    CFG_ADDR_W'(4 * int'(REG_SPAN_THRESHOLD));

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [SMP_W-1:0] in_sample_x;
  logic signed [SMP_W-1:0] in_sample_y;
  logic signed [SMP_W-1:0] in_sample_z;
  logic                    in_restart;
  logic                    in_track;
  logic                    in_commit;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [SMP_W-1:0] out_corrected_x;
  logic signed [SMP_W-1:0] out_corrected_y;
  logic signed [SMP_W-1:0] out_corrected_z;
  logic                    out_accepted_x;
  logic                    out_accepted_y;
  logic                    out_accepted_z;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [CFG_ADDR_W-1:0]   paddr;
  logic [CFG_DATA_W-1:0]   pwdata;
  logic [CFG_DATA_W-1:0]   prdata;
  logic                    pready;

  int fail_count;
  int pending;
  int send_idle_pct;
  int stall_pct;
  int quiet_cycles;

  magnetometer_hard_iron_calibration_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_x     (in_sample_x),
    .in_sample_y     (in_sample_y),
    .in_sample_z     (in_sample_z),
    .in_restart      (in_restart),
    .in_track        (in_track),
    .in_commit       (in_commit),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_corrected_x (out_corrected_x),
    .out_corrected_y (out_corrected_y),
    .out_corrected_z (out_corrected_z),
    .out_accepted_x  (out_accepted_x),
    .out_accepted_y  (out_accepted_y),
    .out_accepted_z  (out_accepted_z),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  hard_iron_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_x     (in_sample_x),
    .in_sample_y     (in_sample_y),
    .in_sample_z     (in_sample_z),
    .in_restart      (in_restart),
    .in_track        (in_track),
    .in_commit       (in_commit),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_corrected_x (out_corrected_x),
    .out_corrected_y (out_corrected_y),
    .out_corrected_z (out_corrected_z),
    .out_accepted_x  (out_accepted_x),
    .out_accepted_y  (out_accepted_y),
    .out_accepted_z  (out_accepted_z),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic ctl_t flags(input bit r, input bit t, input bit c);
    ctl_t f;
    f.restart = r;
    f.track   = t;
    f.commit  = c;
    return f;
  endfunction

  function automatic int pick_sample(input int center, input int spread);
    int v;
    case ($urandom_range(0, 11))
      0: v = -32768;
      1: v = 32767;
      default: begin
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > 32767) v = 32767;
        else if (v < -32768) v = -32768;
      end
    endcase
    return v;
  endfunction

  task automatic send_sample(input int sx, input int sy, input int sz, input ctl_t ctl);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_sample_x <= SMP_W'(sx);
    in_sample_y <= SMP_W'(sy);
    in_sample_z <= SMP_W'(sz);
    in_restart  <= ctl.restart;
    in_track    <= ctl.track;
    in_commit   <= ctl.commit;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_span_threshold(input logic [THR_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SPAN_THRESHOLD_ADDR;
    pwdata  <= CFG_DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // restart, a run of track samples, a commit, then up to three plain samples; random content
  task automatic calibration_pass(output int count);
    int center [3];
    int spread;
    int laps;
    count = 0;
    for (int a = 0; a < 3; a++) center[a] = int'($signed(16'($urandom)));
    case ($urandom_range(0, 3))
      0: spread = 20;
      1: spread = 200;
      2: spread = 3000;
      default: spread = 40000;
    endcase
    send_sample(pick_sample(center[0], spread), pick_sample(center[1], spread),
                pick_sample(center[2], spread),
                flags(1'b1, 1'($urandom), ($urandom_range(0, 3) == 0)));
    count++;
    laps = $urandom_range(1, 8);
    repeat (laps) begin
      send_sample(pick_sample(center[0], spread), pick_sample(center[1], spread),
                  pick_sample(center[2], spread), flags(1'b0, 1'b1, 1'b0));
      count++;
    end
    send_sample(pick_sample(center[0], spread), pick_sample(center[1], spread),
                pick_sample(center[2], spread), flags(1'b0, 1'($urandom), 1'b1));
    count++;
    laps = $urandom_range(0, 3);
    repeat (laps) begin
      send_sample(pick_sample(center[0], 40000), pick_sample(center[1], 40000),
                  pick_sample(center[2], 40000), flags(1'b0, 1'b0, 1'b0));
      count++;
    end
  endtask

  initial begin
    int sent;
    int n;
    logic [THR_W-1:0] limit;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_sample_x   = '0;
    in_sample_y   = '0;
    in_sample_z   = '0;
    in_restart    = 1'b0;
    in_track      = 1'b0;
    in_commit     = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, reset threshold
    send_sample(32767, -32768, 0, flags(1'b0, 1'b0, 1'b0));
    send_sample(1, 2, 3, flags(1'b0, 1'b0, 1'b1));           // commit from reset state
    send_sample(5000, -5000, 0, flags(1'b0, 1'b1, 1'b1));    // track from reset state collapses min/max
    send_sample(-32768, 32767, -3, flags(1'b1, 1'b1, 1'b1)); // zero span
    send_sample(32767, -32768, 4, flags(1'b0, 1'b1, 1'b0));
    send_sample(-32768, 32767, 0, flags(1'b0, 1'b0, 1'b1));  // odd negative sum on x and y
    send_sample(32767, -32768, -101, flags(1'b1, 1'b0, 1'b0));
    send_sample(32000, -32000, -1, flags(1'b0, 1'b1, 1'b1)); // z span at threshold
    send_sample(-32768, 32767, 0, flags(1'b0, 1'b0, 1'b0));  // saturation both ways
    send_sample(32000, -32000, -102, flags(1'b0, 1'b1, 1'b1));
    send_sample(-1, 1, -32768, flags(1'b0, 1'b0, 1'b0));
    send_sample(100, -100, 7, flags(1'b1, 1'b0, 1'b1));
    send_sample(-7, 7, -32768, flags(1'b1, 1'b0, 1'b0));
    send_sample(32767, -32768, 32767, flags(1'b0, 1'b1, 1'b1));
    send_sample(0, 0, 0, flags(1'b0, 1'b0, 1'b1));
    send_sample(-1, -1, -1, flags(1'b1, 1'b1, 1'b0));

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: limit = '0;
        1: limit = '1;
        2: limit = 16'd1;
        3: limit = 16'($urandom);
        default: limit = 16'($urandom_range(0, 300));
      endcase
      write_span_threshold(limit);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 64; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 64; end
        default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase
      @(negedge clk);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) == 0) begin
          send_sample(int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                      int'($signed(16'($urandom))),
                      flags(1'($urandom), 1'($urandom), 1'($urandom)));
          sent++;
        end else begin
          calibration_pass(n);
          sent += n;
        end
      end
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/mhic_pkg.sv
hw/rtl/mhic_axis.sv
hw/rtl/mhic_cfg.sv
hw/rtl/magnetometer_hard_iron_calibration_core.sv
bench/hard_iron_checker.sv
bench/tb_magnetometer_hard_iron_calibration_core.sv
